// ===== rtl/mep_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Mandelbrot escape-time pixel.
package mep_pkg;

  // Number format and counter widths.
  localparam int NUM_WIDTH  = 32;
  localparam int ITER_BITS  = 13;
  localparam int FRAC_BITS  = NUM_WIDTH - 4;
  localparam int OFF_W      = 15;
  localparam int STEP_W     = 32;
  localparam int STEP_FRAC  = 30;
  localparam int SHADE_W    = 8;
  localparam int CNT_W      = ITER_BITS + 1;
  localparam int ROM_SIZE   = 1 << ITER_BITS;
  localparam int ROM_FRAC   = 56;

  // Configuration register indexes.
  localparam logic REG_MAX_ITER   = 1'b0;
  localparam logic REG_PIXEL_STEP = 1'b1;

  // Shared multiplier operands are wide enough for a coordinate or the step.
  localparam int MUL_W      = ((NUM_WIDTH > STEP_W) ? NUM_WIDTH : STEP_W) + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int SQ_W       = 2 * NUM_WIDTH;
  localparam int CP_W       = OFF_W + STEP_W + 1;
  localparam int WIDE_W     = 2 * NUM_WIDTH + 2;

  // Alignment of the offset-times-step product to the coordinate format.
  localparam int C_LSH      = (FRAC_BITS >= STEP_FRAC) ? FRAC_BITS - STEP_FRAC : 0;
  localparam int C_RSH      = (FRAC_BITS >= STEP_FRAC) ? 0 : STEP_FRAC - FRAC_BITS;

  // Terms of the truncated series of exp(-0.01); each is the one before over 100*k.
  localparam logic [63:0] EXP_ONE   = 64'd1 << ROM_FRAC;
  localparam logic [63:0] EXP_T1    = EXP_ONE / 64'd100;
  localparam logic [63:0] EXP_T2    = EXP_T1 / 64'd200;
  localparam logic [63:0] EXP_T3    = EXP_T2 / 64'd300;
  localparam logic [63:0] EXP_T4    = EXP_T3 / 64'd400;
  localparam logic [63:0] EXP_T5    = EXP_T4 / 64'd500;
  localparam logic [63:0] EXP_T6    = EXP_T5 / 64'd600;
  localparam logic [63:0] EXP_T7    = EXP_T6 / 64'd700;
  localparam logic [63:0] EXP_T8    = EXP_T7 / 64'd800;
  localparam logic [63:0] EXP_T9    = EXP_T8 / 64'd900;
  localparam logic [63:0] EXP_T10   = EXP_T9 / 64'd1000;
  localparam logic [63:0] EXP_T11   = EXP_T10 / 64'd1100;
  localparam logic [63:0] EXP_T12   = EXP_T11 / 64'd1200;
  localparam logic [63:0] EXP_RATIO = EXP_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4 - EXP_T5
                                      + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9 + EXP_T10
                                      - EXP_T11 + EXP_T12;

  typedef logic signed [NUM_WIDTH-1:0] num_t;
  typedef logic signed [SQ_W-1:0]      sq_t;
  typedef logic signed [CP_W-1:0]      cprod_t;
  typedef logic signed [WIDE_W-1:0]    wide_t;
  typedef logic signed [MUL_W-1:0]     mul_in_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [ITER_BITS-1:0]        iter_t;
  typedef logic [STEP_W-1:0]           step_t;
  typedef logic signed [OFF_W-1:0]     off_t;
  typedef logic [SHADE_W-1:0]          shade_t;
  typedef logic [ROM_SIZE-1:0][SHADE_W-1:0] shade_tbl_t;

  localparam wide_t WIDE_NUM_MAX = wide_t'({1'b0, {(NUM_WIDTH-1){1'b1}}});
  localparam wide_t WIDE_NUM_MIN = -WIDE_NUM_MAX - wide_t'(1);
  localparam num_t  NEG_HALF     = -num_t'({1'b0, {(NUM_WIDTH-1){1'b0}}} | (num_t'(1) << (FRAC_BITS-1)));
  localparam logic [SQ_W:0] ESC_BOUND = (SQ_W+1)'(1) << (2*FRAC_BITS + 2);

  // Multiplier operand pairs; the step products share cprod, the cross products xp.
  typedef enum logic [2:0] {
    MUL_COL_STEP,
    MUL_ROW_STEP,
    MUL_ZR_ZR,
    MUL_ZI_ZI,
    MUL_ZR_ZI,
    MUL_TR_TR,
    MUL_TI_TI,
    MUL_TR_TI
  } mul_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    mul_en;
    mul_op_t mul_op;
    logic    set_cr;
    logic    set_ci;
    logic    upd_z;
    logic    upd_t;
    logic    rom_rd;
    logic    out_load;
    logic    out_hit;
    cnt_t    count;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic escape;
    logic match;
    logic out_free;
  } status_t;

  // Clamp a wide signed value to the coordinate range.
  function automatic num_t sat_num(input wide_t v);
    num_t r;
    if (v > WIDE_NUM_MAX) begin
      r = WIDE_NUM_MAX[NUM_WIDTH-1:0];
    end else if (v < WIDE_NUM_MIN) begin
      r = WIDE_NUM_MIN[NUM_WIDTH-1:0];
    end else begin
      r = v[NUM_WIDTH-1:0];
    end
    return r;
  endfunction

  // Saturating add of two coordinates.
  function automatic num_t sat_add(input num_t a, input num_t b);
    wide_t s;
    s = wide_t'(a) + wide_t'(b);
    return sat_num(s);
  endfunction

  // Real part of z^2 + c from the two squares, floored and saturated.
  function automatic num_t next_re(input sq_t sr, input sq_t si, input num_t c);
    wide_t d;
    d = wide_t'(sr) - wide_t'(si);
    return sat_add(sat_num(d >>> FRAC_BITS), c);
  endfunction

  // Imaginary part of z^2 + c from the cross product (doubled by the shift).
  function automatic num_t next_im(input sq_t x, input num_t c);
    wide_t w;
    w = wide_t'(x);
    return sat_add(sat_num(w >>> (FRAC_BITS-1)), c);
  endfunction

  // Coordinate from offset times step, floored and saturated.
  function automatic num_t make_c(input cprod_t p);
    wide_t w;
    w = wide_t'(p);
    w = (w <<< C_LSH) >>> C_RSH;
    return sat_num(w);
  endfunction

  // Shade table: 255 - 255*exp(-0.01 n), rounded as the integer recurrence does.
  function automatic shade_tbl_t build_shade_tbl();
    shade_tbl_t    tbl;
    logic [63:0]   p;
    logic [63:0]   y;
    logic [63:0]   up;
    logic [127:0]  q;
    int            n;
    p      = EXP_ONE;
    tbl[0] = '0;
    for (n = 1; n < ROM_SIZE; n++) begin
      q  = {64'd0, p} * {64'd0, EXP_RATIO};
      p  = q[ROM_FRAC+63:ROM_FRAC];
      y  = 64'd255 * p;
      up = (y + ((64'd1 << ROM_FRAC) - 64'd1)) >> ROM_FRAC;
      if (up > 64'd255) begin
        up = 64'd255;
      end
      tbl[n] = SHADE_W'(64'd255 - up);
    end
    return tbl;
  endfunction

  localparam shade_tbl_t SHADE_TBL = build_shade_tbl();

endpackage

// ===== rtl/mandelbrot_escape_pixel.sv =====
// Top level of the Mandelbrot escape-time pixel: ports, configuration registers, core wiring.
//
// One pixel enters per s_axis transaction: tdata carries the signed column and
// row offsets from the image center. One result leaves per pixel on m_axis:
// tdata carries the grey shade and the escape count, tuser the escape flag.
// The registers max_iterations (index 0) and pixel_step (index 1) are written
// through the cfg channel, which is always ready; write them only while idle.
// A pixel runs through setup (column product, row product, imaginary part), then
// through pairs of orbit steps (two main steps, one tortoise step, one loop
// check), and finishes with the shade lookup on an escape and the output load. The pace is
// set by the single shared multiplier, which forms three products per step.
// s_axis_tready is high only while no pixel is in work; the next pixel is
// taken while the previous result still waits in the output register.
// When the receiver stalls with a result pending, the next pixel finishes and
// then holds until the output register frees up.
// Reset (rst, synchronous) loads max_iterations = 1000 and pixel_step =
// 2236962 (4/1920 in unsigned Q2.30) and empties the output register.
module mandelbrot_escape_pixel (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [14:0] col_offset, [29:15] row_offset
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] shade, [20:8] iterations
  output logic        m_axis_tuser,   // [0] escaped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  mep_pkg::iter_t   max_iterations;
  mep_pkg::step_t   pixel_step;
  mep_pkg::cmd_t    cmd;
  mep_pkg::status_t status;
  mep_pkg::shade_t  shade;
  mep_pkg::iter_t   iterations;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= mep_pkg::iter_t'(1000);
      pixel_step     <= mep_pkg::step_t'(2236962);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mep_pkg::REG_MAX_ITER:   max_iterations <= cfg_data[mep_pkg::ITER_BITS-1:0];
        mep_pkg::REG_PIXEL_STEP: pixel_step     <= cfg_data[mep_pkg::STEP_W-1:0];
        default:                 pixel_step     <= pixel_step;
      endcase
    end
  end

  mep_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .max_iterations (max_iterations),
    .status         (status),
    .cmd            (cmd)
  );

  mep_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .col_in     (s_axis_tdata[14:0]),
    .row_in     (s_axis_tdata[29:15]),
    .pixel_step (pixel_step),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .shade      (shade),
    .escaped    (m_axis_tuser),
    .iterations (iterations)
  );

  // Result packing, zero filled to whole bytes.
  assign m_axis_tdata = {3'b000, iterations, shade};

endmodule

// ===== rtl/mep_shade_rom.sv =====
// Constant shade table with a registered read port.
module mep_shade_rom (
  input  logic                   clk,
  input  logic                   rd_en,
  input  mep_pkg::iter_t         addr,
  output mep_pkg::shade_t        data
);

  // Registered lookup; the output holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data <= mep_pkg::SHADE_TBL[addr];
    end
  end

endmodule

// ===== rtl/mep_datapath.sv =====
// Datapath: shared multiplier, orbit and tortoise registers, update unit and result register.
module mep_datapath (
  input  logic              clk,
  input  logic              rst,
  input  mep_pkg::cmd_t     cmd,
  output mep_pkg::status_t  status,
  input  mep_pkg::off_t     col_in,
  input  mep_pkg::off_t     row_in,
  input  mep_pkg::step_t    pixel_step,
  output logic              out_valid,
  input  logic              out_ready,
  output mep_pkg::shade_t   shade,
  output logic              escaped,
  output mep_pkg::iter_t    iterations
);

  mep_pkg::off_t    col;
  mep_pkg::off_t    row;
  mep_pkg::num_t    cr;
  mep_pkg::num_t    ci;
  mep_pkg::num_t    zr;
  mep_pkg::num_t    zi;
  mep_pkg::num_t    tr;
  mep_pkg::num_t    ti;
  mep_pkg::sq_t     sqr;
  mep_pkg::sq_t     sqi;
  mep_pkg::sq_t     tsqr;
  mep_pkg::sq_t     tsqi;
  mep_pkg::sq_t     xp;
  mep_pkg::cprod_t  cprod;

  mep_pkg::mul_in_t mul_a;
  mep_pkg::mul_in_t mul_b;
  mep_pkg::prod_t   prod;
  mep_pkg::num_t    upd_re;
  mep_pkg::num_t    upd_im;
  mep_pkg::iter_t   rom_addr;
  mep_pkg::shade_t  rom_q;
  logic [mep_pkg::SQ_W:0] mag_sum;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cmd.mul_op)
      mep_pkg::MUL_COL_STEP: begin
        mul_a = mep_pkg::mul_in_t'(col);
        mul_b = mep_pkg::mul_in_t'({1'b0, pixel_step});
      end
      mep_pkg::MUL_ROW_STEP: begin
        mul_a = mep_pkg::mul_in_t'(row);
        mul_b = mep_pkg::mul_in_t'({1'b0, pixel_step});
      end
      mep_pkg::MUL_ZR_ZR: begin
        mul_a = mep_pkg::mul_in_t'(zr);
        mul_b = mep_pkg::mul_in_t'(zr);
      end
      mep_pkg::MUL_ZI_ZI: begin
        mul_a = mep_pkg::mul_in_t'(zi);
        mul_b = mep_pkg::mul_in_t'(zi);
      end
      mep_pkg::MUL_ZR_ZI: begin
        mul_a = mep_pkg::mul_in_t'(zr);
        mul_b = mep_pkg::mul_in_t'(zi);
      end
      mep_pkg::MUL_TR_TR: begin
        mul_a = mep_pkg::mul_in_t'(tr);
        mul_b = mep_pkg::mul_in_t'(tr);
      end
      mep_pkg::MUL_TI_TI: begin
        mul_a = mep_pkg::mul_in_t'(ti);
        mul_b = mep_pkg::mul_in_t'(ti);
      end
      mep_pkg::MUL_TR_TI: begin
        mul_a = mep_pkg::mul_in_t'(tr);
        mul_b = mep_pkg::mul_in_t'(ti);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // One z^2 + c update, fed from either the main orbit or the tortoise.
  always_comb begin
    if (cmd.upd_t) begin
      upd_re = mep_pkg::next_re(tsqr, tsqi, cr);
    end else begin
      upd_re = mep_pkg::next_re(sqr, sqi, cr);
    end
    upd_im = mep_pkg::next_im(xp, ci);
  end

  // Escape test on the squares of the newest orbit point, and the cycle test.
  assign mag_sum         = {1'b0, sqr} + {1'b0, sqi};
  assign status.escape   = mag_sum > mep_pkg::ESC_BOUND;
  assign status.match    = (tr == zr) && (ti == zi);
  assign status.out_free = !out_valid || out_ready;

  // Orbit, product and coordinate registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col <= col_in;
      row <= row_in;
      zr  <= '0;
      zi  <= '0;
      tr  <= '0;
      ti  <= '0;
      sqr <= '0;
      sqi <= '0;
    end else begin
      if (cmd.mul_en) begin
        unique case (cmd.mul_op)
          mep_pkg::MUL_COL_STEP,
          mep_pkg::MUL_ROW_STEP: cprod <= prod[mep_pkg::CP_W-1:0];
          mep_pkg::MUL_ZR_ZR:    sqr   <= prod[mep_pkg::SQ_W-1:0];
          mep_pkg::MUL_ZI_ZI:    sqi   <= prod[mep_pkg::SQ_W-1:0];
          mep_pkg::MUL_TR_TR:    tsqr  <= prod[mep_pkg::SQ_W-1:0];
          mep_pkg::MUL_TI_TI:    tsqi  <= prod[mep_pkg::SQ_W-1:0];
          mep_pkg::MUL_ZR_ZI,
          mep_pkg::MUL_TR_TI:    xp    <= prod[mep_pkg::SQ_W-1:0];
          default:               xp    <= xp;
        endcase
      end
      if (cmd.set_cr) begin
        cr <= mep_pkg::sat_add(mep_pkg::make_c(cprod), mep_pkg::NEG_HALF);
      end
      if (cmd.set_ci) begin
        ci <= mep_pkg::make_c(cprod);
      end
      if (cmd.upd_z) begin
        zr <= upd_re;
        zi <= upd_im;
      end
      if (cmd.upd_t) begin
        tr <= upd_re;
        ti <= upd_im;
      end
    end
  end

  // Counts past the table's end read its last entry.
  assign rom_addr = cmd.count[mep_pkg::CNT_W-1] ? '1 : cmd.count[mep_pkg::ITER_BITS-1:0];

  mep_shade_rom u_rom (
    .clk   (clk),
    .rd_en (cmd.rom_rd),
    .addr  (rom_addr),
    .data  (rom_q)
  );

  // Result register; it frees the core while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      shade      <= cmd.out_hit ? rom_q : '0;
      escaped    <= cmd.out_hit;
      iterations <= cmd.out_hit ? cmd.count[mep_pkg::ITER_BITS-1:0] : '0;
    end
  end

endmodule

// ===== rtl/mep_ctrl.sv =====
// Controller: sequences one pixel through setup, paired orbit steps and the tortoise step.
module mep_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mep_pkg::iter_t    max_iterations,
  input  mep_pkg::status_t  status,
  output mep_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_C_COL,
    S_C_ROW,
    S_C_IM,
    S_LOOP,
    S_Z_X,
    S_Z_UPD,
    S_Z_RR,
    S_Z_II,
    S_Z_ESC,
    S_T_RR,
    S_T_II,
    S_T_X,
    S_T_UPD,
    S_T_CMP,
    S_ROM,
    S_OUT
  } state_t;

  state_t        state;
  mep_pkg::cnt_t iter;
  logic          second;
  logic          hit;

  assign in_ready = (state == S_IDLE);

  // State, step count, pair phase and escape flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      iter   <= mep_pkg::cnt_t'(1);
      second <= 1'b0;
      hit    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state  <= S_C_COL;
            iter   <= mep_pkg::cnt_t'(1);
            second <= 1'b0;
            hit    <= 1'b0;
          end
        end
        S_C_COL: state <= S_C_ROW;
        S_C_ROW: state <= S_C_IM;
        S_C_IM:  state <= S_LOOP;
        S_LOOP: begin
          if (iter < mep_pkg::cnt_t'(max_iterations)) begin
            state <= S_Z_X;
          end else begin
            state <= S_OUT;
          end
        end
        S_Z_X:   state <= S_Z_UPD;
        S_Z_UPD: state <= S_Z_RR;
        S_Z_RR:  state <= S_Z_II;
        S_Z_II:  state <= S_Z_ESC;
        S_Z_ESC: begin
          if (status.escape) begin
            hit   <= 1'b1;
            state <= S_ROM;
          end else begin
            iter <= iter + mep_pkg::cnt_t'(1);
            if (!second) begin
              second <= 1'b1;
              state  <= S_Z_X;
            end else begin
              second <= 1'b0;
              state  <= S_T_RR;
            end
          end
        end
        S_T_RR:  state <= S_T_II;
        S_T_II:  state <= S_T_X;
        S_T_X:   state <= S_T_UPD;
        S_T_UPD: state <= S_T_CMP;
        S_T_CMP: begin
          if (status.match) begin
            state <= S_OUT;
          end else begin
            state <= S_LOOP;
          end
        end
        S_ROM: state <= S_OUT;
        S_OUT: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command decode.
  always_comb begin
    cmd          = '0;
    cmd.mul_op   = mep_pkg::MUL_COL_STEP;
    cmd.count    = iter;
    cmd.out_hit  = hit;
    cmd.load     = (state == S_IDLE) && in_valid;
    unique case (state)
      S_C_COL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mep_pkg::MUL_COL_STEP;
      end
      S_C_ROW: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mep_pkg::MUL_ROW_STEP;
        cmd.set_cr = 1'b1;
      end
      S_C_IM:  cmd.set_ci = 1'b1;
      S_Z_X: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mep_pkg::MUL_ZR_ZI;
      end
      S_Z_UPD: cmd.upd_z = 1'b1;
      S_Z_RR: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mep_pkg::MUL_ZR_ZR;
      end
      S_Z_II: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mep_pkg::MUL_ZI_ZI;
      end
      S_T_RR: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mep_pkg::MUL_TR_TR;
      end
      S_T_II: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mep_pkg::MUL_TI_TI;
      end
      S_T_X: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mep_pkg::MUL_TR_TI;
      end
      S_T_UPD: cmd.upd_t = 1'b1;
      S_ROM:   cmd.rom_rd = 1'b1;
      S_OUT:   cmd.out_load = status.out_free;
      default: cmd.load = cmd.load;
    endcase
  end

`ifndef SYNTHESIS
  // An accepted pixel always starts with the column product.
  a_load_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_C_COL))
    else $error("pixel transaction did not start the setup sequence");

  // An escape seen after a step goes straight to the shade lookup.
  a_escape_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_Z_ESC && status.escape) |=> (state == S_ROM && hit))
    else $error("escape did not lead to the shade lookup");

  // A reported escape carries a count inside the table range.
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && hit) |->
      (iter != '0 && iter < mep_pkg::cnt_t'(mep_pkg::ROM_SIZE)))
    else $error("escape count out of range");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the Mandelbrot escape-time pixel block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mep_pkg::*;

  localparam iter_t RESET_MAX_ITER = 13'd1000;
  localparam step_t RESET_STEP     = 32'd2236962;
  localparam step_t FULL_STEP      = 32'hFFFF_FFFF;
  localparam iter_t FULL_MAX_ITER  = 13'd8191;

  localparam longint NUM_HI = (longint'(1) <<< (NUM_WIDTH - 1)) - 1;
  localparam longint NUM_LO = -NUM_HI - 1;
  localparam int     WATCHDOG_LIMIT = 300000;
  localparam int     SEGMENTS = 12;
  localparam int     PIXELS_PER_SEGMENT = 50;

  // Handshake idling patterns.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One result as it leaves the block.
  typedef struct packed {
    shade_t shade;
    logic   escaped;
    iter_t  iterations;
  } pixel_result_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    logic          wr_cfg;
    iter_t         max_it;
    step_t         step;
    off_t          col;
    off_t          row;
    logic          typed;
    pixel_result_t want;
  } directed_row_t;

  localparam pixel_result_t INSIDE  = '{8'd0, 1'b0, 13'd0};
  localparam pixel_result_t FAR_OUT = '{8'd2, 1'b1, 13'd1};

  // Directed table: reset settings, extremes, small limit, zero step, step extremes.
  directed_row_t directed [0:22] = '{
    '{1'b0, 13'd0,          32'd0,      15'sd0,      15'sd0,      1'b1, INSIDE},
    '{1'b0, 13'd0,          32'd0,      -15'sd16384, -15'sd16384, 1'b1, FAR_OUT},
    '{1'b0, 13'd0,          32'd0,      15'sd16383,  15'sd16383,  1'b1, FAR_OUT},
    '{1'b0, 13'd0,          32'd0,      -15'sd16384, 15'sd16383,  1'b0, INSIDE},
    '{1'b0, 13'd0,          32'd0,      15'sd16383,  -15'sd16384, 1'b0, INSIDE},
    '{1'b0, 13'd0,          32'd0,      -15'sd240,   15'sd0,      1'b0, INSIDE},
    '{1'b0, 13'd0,          32'd0,      -15'sd60,    15'sd200,    1'b0, INSIDE},
    '{1'b0, 13'd0,          32'd0,      15'sd40,     15'sd150,    1'b0, INSIDE},
    '{1'b0, 13'd0,          32'd0,      -15'sd355,   15'sd40,     1'b0, INSIDE},
    '{1'b1, 13'd1,          RESET_STEP, 15'sd16383,  15'sd16383,  1'b1, INSIDE},
    '{1'b0, 13'd0,          32'd0,      15'sd0,      15'sd0,      1'b1, INSIDE},
    '{1'b1, 13'd0,          RESET_STEP, -15'sd16384, -15'sd16384, 1'b1, INSIDE},
    '{1'b1, 13'd2,          32'd0,      15'sd16383,  -15'sd16384, 1'b0, INSIDE},
    '{1'b1, FULL_MAX_ITER,  FULL_STEP,  15'sd0,      15'sd0,      1'b0, INSIDE},
    '{1'b0, 13'd0,          32'd0,      15'sd1,      15'sd0,      1'b0, INSIDE},
    '{1'b0, 13'd0,          32'd0,      -15'sd1,     -15'sd1,     1'b0, INSIDE},
    '{1'b0, 13'd0,          32'd0,      15'sd1,      -15'sd1,     1'b0, INSIDE},
    '{1'b1, FULL_MAX_ITER,  32'd1,      15'sd16383,  -15'sd16384, 1'b0, INSIDE},
    '{1'b0, 13'd0,          32'd0,      -15'sd16384, 15'sd16383,  1'b0, INSIDE},
    '{1'b1, FULL_MAX_ITER,  RESET_STEP, -15'sd300,   15'sd250,    1'b0, INSIDE},
    '{1'b0, 13'd0,          32'd0,      -15'sd130,   15'sd305,    1'b0, INSIDE},
    '{1'b1, RESET_MAX_ITER, RESET_STEP, -15'sd150,   15'sd310,    1'b0, INSIDE},
    '{1'b0, 13'd0,          32'd0,      15'sd85,     15'sd250,    1'b0, INSIDE}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // Own copy of the registers and the shade table.
  iter_t  cur_max_iter = RESET_MAX_ITER;
  step_t  cur_step     = RESET_STEP;
  shade_t shade_lut [ROM_SIZE];

  pixel_result_t pixel_results_due [$];
  idle_mode_t    idle_mode = IDLE_NONE;
  int            failures = 0;
  int            pixels_sent = 0;
  int            escapes_seen = 0;
  int            settings_used = 1;
  int            quiet_cycles = 0;

  mandelbrot_escape_pixel dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Clamp to the signed coordinate range.
  function automatic longint clamp_num(input longint v);
    if (v > NUM_HI) begin
      return NUM_HI;
    end
    if (v < NUM_LO) begin
      return NUM_LO;
    end
    return v;
  endfunction

  // Offset times step, floored to the coordinate format.
  function automatic longint scale_offset(input off_t off);
    longint p;
    p = longint'(off) * longint'(cur_step);
    return clamp_num(p >>> (STEP_FRAC - FRAC_BITS));
  endfunction

  // One orbit step z = z^2 + c with floored, saturated parts.
  function automatic void orbit_step(inout longint re, inout longint im,
                                     input longint cre, input longint cim);
    longint nre;
    longint nim;
    nre = clamp_num(clamp_num((re * re - im * im) >>> FRAC_BITS) + cre);
    nim = clamp_num(clamp_num((re * im) >>> (FRAC_BITS - 1)) + cim);
    re = nre;
    im = nim;
  endfunction

  // Magnitude squared strictly above four.
  function automatic bit beyond_radius(input longint re, input longint im);
    longint unsigned sum;
    sum = 64'(unsigned'(re * re)) + 64'(unsigned'(im * im));
    return sum > (64'd1 << (2 * FRAC_BITS + 2));
  endfunction

  // Escape-time result of one pixel under the current register values.
  function automatic pixel_result_t escape_time_of(input off_t col, input off_t row);
    longint        cr;
    longint        ci;
    longint        zr;
    longint        zi;
    longint        tr;
    longint        ti;
    int            count;
    int            hit;
    pixel_result_t r;
    cr = clamp_num(scale_offset(col) - (longint'(1) <<< (FRAC_BITS - 1)));
    ci = scale_offset(row);
    zr = 0;
    zi = 0;
    tr = 0;
    ti = 0;
    count = 1;
    hit = 0;
    // The hare takes two steps, the tortoise one; equal orbits mean a cycle.
    while (count < int'(cur_max_iter)) begin
      orbit_step(zr, zi, cr, ci);
      if (beyond_radius(zr, zi)) begin
        hit = count;
        break;
      end
      count++;
      orbit_step(zr, zi, cr, ci);
      if (beyond_radius(zr, zi)) begin
        hit = count;
        break;
      end
      count++;
      orbit_step(tr, ti, cr, ci);
      if (tr == zr && ti == zi) begin
        break;
      end
    end
    if (hit != 0) begin
      r.shade      = shade_lut[(hit > ROM_SIZE - 1) ? ROM_SIZE - 1 : hit];
      r.escaped    = 1'b1;
      r.iterations = iter_t'(hit);
    end else begin
      r = INSIDE;
    end
    return r;
  endfunction

  // Offset range that lands c in the interesting part of the plane.
  function automatic int offset_span(input step_t s);
    longint span;
    if (s == 0) begin
      return 16383;
    end
    span = (longint'(3) <<< 29) / longint'(s);
    if (span > 16383) begin
      span = 16383;
    end
    if (span < 1) begin
      span = 1;
    end
    return int'(span);
  endfunction

  // Mostly offsets near the set, the rest anywhere in the field.
  function automatic off_t pick_offset(input int span);
    if ($urandom_range(0, 4) == 0) begin
      return off_t'($urandom());
    end
    return off_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic bit sender_waits();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 71;
      IDLE_BOTH:   return $urandom_range(0, 99) < 23;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 71;
      IDLE_BOTH:     return $urandom_range(0, 99) < 23;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Send one pixel; called at a falling edge, returns at a falling edge.
  task automatic send_pixel(input off_t col, input off_t row, input logic typed,
                            input pixel_result_t want);
    while (sender_waits()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, row, col};
    do @(posedge clk); while (!s_axis_tready);
    pixel_results_due.push_back(typed ? want : escape_time_of(col, row));
    pixels_sent++;
    @(negedge clk);
  endtask

  // Stop sending and wait until every pending result has come out.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pixel_results_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // One register write transaction.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MAX_ITER) begin
      cur_max_iter = value[ITER_BITS-1:0];
    end else begin
      cur_step = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input iter_t max_it, input step_t step);
    wait_drain();
    write_reg(REG_MAX_ITER, 32'(max_it));
    write_reg(REG_PIXEL_STEP, step);
    settings_used++;
  endtask

  // Receiver: random stalls, and a check of every result transaction.
  always @(negedge clk) begin
    m_axis_tready <= !receiver_stalls();
  end

  always @(posedge clk) begin : check_results
    pixel_result_t got;
    pixel_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[20:8]};
      if (got.escaped) begin
        escapes_seen++;
      end
      if (pixel_results_due.size() == 0) begin
        note_failure($sformatf("result with no pixel pending: shade %0d escaped %0d iter %0d",
                               got.shade, got.escaped, got.iterations));
      end else begin
        want = pixel_results_due.pop_front();
        if (got !== want) begin
          note_failure($sformatf(
            "expected shade %0d escaped %0d iter %0d, got shade %0d escaped %0d iter %0d",
            want.shade, want.escaped, want.iterations,
            got.shade, got.escaped, got.iterations));
        end
      end
    end
  end

  // Watchdog: end the run when no transaction happens for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] ERROR: no transaction for %0d cycles", $realtime, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    longint unsigned term;
    longint unsigned ratio;
    longint unsigned prod;
    longint unsigned up;
    logic [127:0]    q;
    int              k;
    int              seg;
    int              n;
    int              span;
    iter_t           max_it;
    step_t           step;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_MAX_ITER;
    cfg_data      = '0;

    // Shade table from the truncated series of exp(-0.01) and its powers.
    term  = 64'd1 << ROM_FRAC;
    ratio = term;
    prod  = term;
    for (k = 1; k <= 12; k++) begin
      term = term / (64'd100 * 64'(k));
      ratio = (k % 2 == 1) ? ratio - term : ratio + term;
    end
    shade_lut[0] = '0;
    for (n = 1; n < ROM_SIZE; n++) begin
      q    = {64'd0, prod} * {64'd0, ratio};
      prod = q[ROM_FRAC +: 64];
      up   = (64'd255 * prod + ((64'd1 << ROM_FRAC) - 64'd1)) >> ROM_FRAC;
      shade_lut[n] = shade_t'(64'd255 - ((up > 64'd255) ? 64'd255 : up));
    end

    // Synchronous reset.
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table.
    for (n = 0; n < $size(directed); n++) begin
      if (directed[n].wr_cfg) begin
        configure(directed[n].max_it, directed[n].step);
      end
      send_pixel(directed[n].col, directed[n].row, directed[n].typed, directed[n].want);
    end

    // Random segments, each with its own settings and idling pattern.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      idle_mode = idle_mode_t'(seg % 4);
      case ($urandom_range(0, 9))
        0, 1:    max_it = 13'd2;
        2, 3, 4: max_it = iter_t'($urandom_range(3, 40));
        5, 6, 7: max_it = iter_t'($urandom_range(41, 300));
        default: max_it = RESET_MAX_ITER;
      endcase
      case ($urandom_range(0, 3))
        0:       step = RESET_STEP;
        1:       step = step_t'((64'd1 << 32) / 64'($urandom_range(64, 4096)));
        2:       step = $urandom();
        default: step = step_t'($urandom_range(1, 1 << 20));
      endcase
      configure(max_it, step);
      span = offset_span(step);
      for (n = 0; n < PIXELS_PER_SEGMENT; n++) begin
        // Now and then hold off until the block has emptied.
        if ($urandom_range(0, 99) < 3) begin
          wait_drain();
        end
        send_pixel(pick_offset(span), pick_offset(span), 1'b0, INSIDE);
      end
    end

    // Let everything come out, then allow a grace period.
    wait_drain();
    idle_mode = IDLE_NONE;
    repeat (100) @(negedge clk);
    if (pixel_results_due.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pixel_results_due.size()));
    end

    $display("Ran %0d pixels (%0d escaped) under %0d register settings,", pixels_sent,
             escapes_seen, settings_used);
    $display("with four idling patterns on the pixel and result streams; %0d failures.",
             failures);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mep_pkg.sv
rtl/mep_shade_rom.sv
rtl/mep_datapath.sv
rtl/mep_ctrl.sv
rtl/mandelbrot_escape_pixel.sv
tb/testbench.sv
